// File: rtl/brf_pkg.sv
// shared types, constants and helpers for the byte ring fifo
`timescale 1ns / 1ps

package brf_pkg;

  // fixed field widths
  localparam int BYTE_W     = 8;
  localparam int DATA_W     = 64;
  localparam int BYTE_CNT_W = 4;
  localparam int COUNT_W    = 11;
  localparam int CFG_W      = 11;

  // default geometry
  localparam int DEPTH_DEF = 1024;
  localparam int LANES_DEF = 8;

  // register port
  localparam int APB_DATA_W = 32;
  localparam int ADDR_W     = 3;
  localparam int REG_IDX_W  = 1;
  localparam logic [REG_IDX_W-1:0] REG_CAPACITY = 1'b0;
  localparam logic [CFG_W-1:0]     CAP_RESET    = 11'd1024;

  // request kinds
  typedef enum logic [1:0] {
    REQ_PUSH  = 2'd0,
    REQ_POP   = 2'd1,
    REQ_PEEK  = 2'd2,
    REQ_CLEAR = 2'd3
  } req_type_t;

  typedef struct packed {
    req_type_t               req_type;
    logic [BYTE_CNT_W-1:0]   byte_count;
    logic [DATA_W-1:0]       push_bytes;
  } in_item_t;

  typedef struct packed {
    logic                    accepted;
    logic [DATA_W-1:0]       read_bytes;
    logic [COUNT_W-1:0]      bytes_stored;
    logic [COUNT_W-1:0]      bytes_free;
  } out_item_t;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_WRITE,
    S_READ,
    S_DRAIN,
    S_DONE
  } seq_state_t;

  // width of counts and capacity: holds DEPTH and any register value
  function automatic int cap_width(input int depth);
    int w;
    begin
      w = $clog2(depth + 1);
      return (w > CFG_W) ? w : CFG_W;
    end
  endfunction

endpackage

// File: rtl/brf_ram.sv
// generic single-port-write, registered-read ram
`timescale 1ns / 1ps

module brf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/brf_seq.sv
// ring pointers, byte count and the byte-at-a-time store sequencer
`timescale 1ns / 1ps

module brf_seq #(
  parameter int DEPTH = brf_pkg::DEPTH_DEF,
  parameter int LANES = brf_pkg::LANES_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     req_valid,
  output logic                                     req_stall,
  input  brf_pkg::in_item_t                        req_data,
  input  logic                                     cap_write,
  input  logic [brf_pkg::cap_width(DEPTH)-1:0]     cap_eff,
  output logic                                     done_valid,
  input  logic                                     done_stall,
  output brf_pkg::out_item_t                       done_item
);

  import brf_pkg::*;

  localparam int AW     = $clog2(DEPTH);
  localparam int CAP_W  = cap_width(DEPTH);
  localparam int CNT_W  = $clog2(LANES + 1);
  localparam int LANE_W = (LANES > 1) ? $clog2(LANES) : 1;

  seq_state_t state, state_next;

  logic [AW-1:0]      rd_pos;
  logic [AW-1:0]      wr_pos;
  logic [CAP_W-1:0]   count;
  logic [AW-1:0]      ptr;
  logic [CNT_W-1:0]   idx;
  logic [CNT_W-1:0]   last_idx;
  logic               is_pop;
  logic [DATA_W-1:0]  data_q;
  logic [DATA_W-1:0]  acc;
  logic               rd_pend;
  logic [LANE_W-1:0]  rd_lane;
  logic               r_accepted;
  logic [CAP_W-1:0]   r_stored;
  logic [CAP_W-1:0]   r_free;

  logic [CAP_W-1:0]   req_cnt;
  logic               cnt_ok;
  logic [CAP_W-1:0]   free_now;
  logic               push_ok;
  logic               pop_ok;
  logic [CAP_W-1:0]   ptr_sum;
  logic [AW-1:0]      ptr_next;
  logic               at_last;

  logic               ram_we;
  logic               ram_re;
  logic [BYTE_W-1:0]  ram_wdata;
  logic [BYTE_W-1:0]  ram_rdata;

  // request checks against space and fill
  assign req_cnt  = CAP_W'(req_data.byte_count);
  assign cnt_ok   = (req_data.byte_count != '0) &&
                    (req_data.byte_count <= BYTE_CNT_W'(LANES));
  assign free_now = cap_eff - count;
  assign push_ok  = cnt_ok && (free_now >= req_cnt);
  assign pop_ok   = cnt_ok && (count >= req_cnt);

  // pointer step with wrap at the ring capacity
  assign ptr_sum  = CAP_W'(ptr) + CAP_W'(1);
  assign ptr_next = (ptr_sum >= cap_eff) ? '0 : AW'(ptr_sum);
  assign at_last  = (idx == last_idx);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          case (req_data.req_type)
            REQ_PUSH:  state_next = push_ok ? S_WRITE : S_DONE;
            REQ_POP:   state_next = pop_ok ? S_READ : S_DONE;
            REQ_PEEK:  state_next = pop_ok ? S_READ : S_DONE;
            REQ_CLEAR: state_next = S_DONE;
            default:   state_next = S_DONE;
          endcase
        end
      end
      S_WRITE: begin
        if (at_last) state_next = S_DONE;
      end
      S_READ: begin
        if (at_last) state_next = S_DRAIN;
      end
      S_DRAIN: state_next = S_DONE;
      S_DONE: begin
        if (!done_stall) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    req_stall  = (state != S_IDLE);
    done_valid = (state == S_DONE);
    ram_we     = (state == S_WRITE);
    ram_re     = (state == S_READ);
  end

  assign ram_wdata = data_q[BYTE_W*idx[LANE_W-1:0] +: BYTE_W];

  assign done_item.accepted     = r_accepted;
  assign done_item.read_bytes   = acc;
  assign done_item.bytes_stored = r_stored[COUNT_W-1:0];
  assign done_item.bytes_free   = r_free[COUNT_W-1:0];

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      rd_pos  <= '0;
      wr_pos  <= '0;
      count   <= '0;
      rd_pend <= 1'b0;
    end else begin
      state   <= state_next;
      rd_pend <= (state == S_READ);
      // a capacity write empties the ring
      if (cap_write) begin
        rd_pos <= '0;
        wr_pos <= '0;
        count  <= '0;
      end else begin
        case (state)
          S_IDLE: begin
            if (req_valid) begin
              case (req_data.req_type)
                REQ_PUSH: begin
                  if (push_ok) count <= count + req_cnt;
                end
                REQ_POP: begin
                  if (pop_ok) count <= count - req_cnt;
                end
                REQ_CLEAR: begin
                  rd_pos <= '0;
                  wr_pos <= '0;
                  count  <= '0;
                end
                default: ;
              endcase
            end
          end
          S_WRITE: begin
            if (at_last) wr_pos <= ptr_next;
          end
          S_READ: begin
            if (at_last && is_pop) rd_pos <= ptr_next;
          end
          default: ;
        endcase
      end
    end
  end

  // request payload and result fields
  always_ff @(posedge clk) begin
    rd_lane <= idx[LANE_W-1:0];
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          idx        <= '0;
          last_idx   <= CNT_W'(req_data.byte_count - BYTE_CNT_W'(1));
          data_q     <= req_data.push_bytes;
          acc        <= '0;
          is_pop     <= (req_data.req_type == REQ_POP);
          case (req_data.req_type)
            REQ_PUSH: begin
              ptr        <= wr_pos;
              r_accepted <= push_ok;
              r_stored   <= push_ok ? count + req_cnt : count;
              r_free     <= push_ok ? free_now - req_cnt : free_now;
            end
            REQ_POP: begin
              ptr        <= rd_pos;
              r_accepted <= pop_ok;
              r_stored   <= pop_ok ? count - req_cnt : count;
              r_free     <= pop_ok ? free_now + req_cnt : free_now;
            end
            REQ_PEEK: begin
              ptr        <= rd_pos;
              r_accepted <= pop_ok;
              r_stored   <= count;
              r_free     <= free_now;
            end
            REQ_CLEAR: begin
              r_accepted <= 1'b1;
              r_stored   <= '0;
              r_free     <= cap_eff;
            end
            default: begin
              r_accepted <= 1'b0;
              r_stored   <= count;
              r_free     <= free_now;
            end
          endcase
        end
      end
      S_WRITE, S_READ: begin
        ptr <= ptr_next;
        idx <= idx + CNT_W'(1);
      end
      default: ;
    endcase
    // gather read data in the cycle after each read
    if (rd_pend) begin
      acc[BYTE_W*rd_lane +: BYTE_W] <= ram_rdata;
    end
  end

  // byte store
  brf_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ptr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ptr),
    .rdata (ram_rdata)
  );

endmodule

// File: rtl/byte_ring_fifo_block_access.sv
// byte ring fifo with block push, pop, peek and clear: top level
// Requests enter on req_valid/req_stall/req_data, results leave on
// res_valid/res_stall/res_data, one result for each request.
// A request is a push, pop, peek or clear of 1 to LANES bytes; the ring
// size comes from the capacity register on the APB port (offset 0).
// The store is one byte-wide synchronous RAM; the sequencer moves one byte
// per cycle through its single access port. An accepted push goes from S_IDLE
// through S_WRITE to S_DONE, an accepted pop or peek through S_READ and
// S_DRAIN (for the registered read) to S_DONE, and a clear or rejected
// request goes straight to S_DONE. The result shows on res_valid once
// S_DONE hands it to the output register, and the next request can be
// taken when the sequencer is back in S_IDLE.
// A finished result sits in the
// output register while the next request is already being worked on;
// if res_stall holds a result there, a following result waits in the
// sequencer and req_stall stays high.
// Reset empties the ring and sets the capacity register to 1024.
// Writing the capacity register also empties the ring.
`timescale 1ns / 1ps

module byte_ring_fifo_block_access #(
  parameter int DEPTH = brf_pkg::DEPTH_DEF,
  parameter int LANES = brf_pkg::LANES_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              req_valid,
  output logic                              req_stall,
  input  brf_pkg::in_item_t                 req_data,
  output logic                              res_valid,
  input  logic                              res_stall,
  output brf_pkg::out_item_t                res_data,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [brf_pkg::ADDR_W-1:0]        paddr,
  input  logic [brf_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [brf_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready
);

  import brf_pkg::*;

  localparam int CAP_W = cap_width(DEPTH);

  logic [CFG_W-1:0]     cap_raw;
  logic [CAP_W-1:0]     cap_eff;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 cap_write;

  logic                 done_valid;
  logic                 done_stall;
  out_item_t            done_item;

  // register access
  assign pready    = 1'b1;
  assign reg_idx   = paddr[ADDR_W-1:2];
  assign cap_write = psel && penable && pwrite && pready && (reg_idx == REG_CAPACITY);
  assign prdata    = (reg_idx == REG_CAPACITY) ? APB_DATA_W'(cap_raw) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cap_raw <= CAP_RESET;
    end else if (cap_write) begin
      cap_raw <= pwdata[CFG_W-1:0];
    end
  end

  // zero acts as one, above the store acts as the store size
  always_comb begin
    if (cap_raw == '0) begin
      cap_eff = CAP_W'(1);
    end else if (CAP_W'(cap_raw) > CAP_W'(DEPTH)) begin
      cap_eff = CAP_W'(DEPTH);
    end else begin
      cap_eff = CAP_W'(cap_raw);
    end
  end

  // sequencer with the byte store
  brf_seq #(
    .DEPTH (DEPTH),
    .LANES (LANES)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req_data   (req_data),
    .cap_write  (cap_write),
    .cap_eff    (cap_eff),
    .done_valid (done_valid),
    .done_stall (done_stall),
    .done_item  (done_item)
  );

  // output register
  assign done_stall = res_valid && res_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (done_valid && !done_stall) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done_valid && !done_stall) begin
      res_data <= done_item;
    end
  end

`ifndef SYNTH
  // an accepted request keeps the sequencer busy in the following cycle
  a_busy_after_request: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> req_stall)
    else $error("request accepted but sequencer not busy");

  // a result handed over always lands in the output register
  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    (done_valid && !done_stall) |=> res_valid)
    else $error("result lost between sequencer and output register");

  // a rejected request returns no data
  a_reject_no_data: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_data.accepted) |-> (res_data.read_bytes == '0))
    else $error("rejected request carries read data");
`endif

endmodule
